@@ design/afu_pkg.sv @@
package afu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 11;

  localparam int IP           = 30;
  localparam int FW           = 30;
  localparam int TW           = 31;
  localparam int SUM_W        = 33;
  localparam int MW           = 5;
  localparam int SERIES_TERMS = 20;
  localparam int MUL_STEPS    = 31;
  localparam int QW           = 31;
  localparam int NUM_W        = 64;
  localparam int DEN_W        = 34;
  localparam int YW_MAX       = 32;

  localparam logic [63:0] ONE_I = 64'd1 << IP;

  typedef enum logic [1:0] {
    KIND_IDENT    = 2'd0,
    KIND_RELU     = 2'd1,
    KIND_SOFTSIGN = 2'd2,
    KIND_TANH     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_DIRECT = 3'd0,
    OP_SS_VAL = 3'd1,
    OP_SS_DER = 3'd2,
    OP_TH_VAL = 3'd3,
    OP_TH_DER = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              neg;
    logic              big;
    logic [YW_MAX-1:0] y_early;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } sb_t;

  typedef struct packed {
    logic [FW-1:0] f;
    logic [MW-1:0] m;
    sb_t           sb;
  } exp_tag_t;

  // Truncated series for exp(-1), evaluated the same way as the datapath. With the
  // fraction at one, each term is one over k factorial truncated in Q30, and all
  // terms past the twelfth are zero.
  localparam logic [63:0] E_INV64 = ONE_I - ONE_I / 64'd1 + ONE_I / 64'd2
      - ONE_I / 64'd6 + ONE_I / 64'd24 - ONE_I / 64'd120 + ONE_I / 64'd720
      - ONE_I / 64'd5040 + ONE_I / 64'd40320 - ONE_I / 64'd362880
      + ONE_I / 64'd3628800 - ONE_I / 64'd39916800 + ONE_I / 64'd479001600;
  localparam logic [TW-1:0] E_INV = E_INV64[TW-1:0];

endpackage

@@ design/afu_if.sv @@
interface afu_in_if #(
  parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [DATA_WIDTH-1:0] x;

  modport source (output valid, output func, output x, input ready);
  modport sink (input valid, input func, input x, output ready);
endinterface

interface afu_out_if #(
  parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] y;

  modport source (output valid, output y, input ready);
  modport sink (input valid, input y, output ready);
endinterface

@@ design/activation_function_unit.sv @@
// Channel  Dir  Handshake     Payload
// in_chan  in   valid/ready   func, x (signed Q4.11)
// out_chan out  valid/ready   y (signed Q4.11)
// cfg      in   cfg_we        cfg_wdata (activation kind)
//
// One request is taken per cycle while the output request is not waiting.
// The pipeline is mostly the 20-term exp series (two multiply stages per term),
// the 31 exp(-1) scaling stages and the 31-stage restoring divider.
// Reset clears the valid bits and sets the kind to identity.
// The whole pipeline holds while the output request waits.
module activation_function_unit #(
  parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  afu_in_if.sink           in_chan,
  afu_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata
);

  localparam int IP = afu_pkg::IP;
  localparam int TW = afu_pkg::TW;
  localparam int NW = afu_pkg::NUM_W;
  localparam int DW = afu_pkg::DEN_W;
  localparam logic [63:0] ONE_OUT = 64'd1 << FRAC_BITS;
  localparam logic [63:0] BIG_LIM = 64'd16 << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] ONE_SAT = (FRAC_BITS >= DATA_WIDTH - 1)
      ? DATA_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1)
      : DATA_WIDTH'(ONE_OUT);

  afu_pkg::kind_t        kind_r;
  logic                  en;

  logic [DATA_WIDTH-1:0] xu;
  logic                  neg;
  logic [DATA_WIDTH-1:0] mag;
  logic [63:0]           mag64;
  logic [63:0]           d;
  logic [63:0]           a;
  logic [DATA_WIDTH-1:0] y_dir;
  afu_pkg::exp_tag_t     tag_nxt;
  afu_pkg::exp_tag_t     tag0_r;
  logic                  v0_r;

  logic                  exp_valid;
  logic [TW-1:0]         exp_t;
  afu_pkg::sb_t          exp_sb;
  afu_pkg::sb_t          prep_nxt;
  afu_pkg::sb_t          prep_r;
  logic                  vp_r;

  logic                  div_valid;
  logic [afu_pkg::QW-1:0] div_q;
  afu_pkg::sb_t          div_sb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= afu_pkg::KIND_IDENT;
    end else if (cfg_we) begin
      kind_r <= afu_pkg::kind_t'(cfg_wdata);
    end
  end

  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  assign xu    = in_chan.x;
  assign neg   = xu[DATA_WIDTH-1];
  assign mag   = neg ? (~xu + 1'b1) : xu;
  assign mag64 = 64'(mag);
  assign d     = ONE_OUT + mag64;
  assign a     = mag64 << (IP + 1 - FRAC_BITS);

  always_comb begin
    y_dir               = xu;
    tag_nxt.f           = a[afu_pkg::FW-1:0];
    tag_nxt.m           = a[IP+afu_pkg::MW-1:IP];
    tag_nxt.sb.op       = afu_pkg::OP_DIRECT;
    tag_nxt.sb.neg      = neg;
    tag_nxt.sb.big      = mag64 >= BIG_LIM;
    tag_nxt.sb.num      = '0;
    tag_nxt.sb.den      = '0;
    case (kind_r)
      afu_pkg::KIND_IDENT: begin
        y_dir = in_chan.func ? ONE_SAT : xu;
      end
      afu_pkg::KIND_RELU: begin
        if (in_chan.func) begin
          y_dir = (!neg && (mag != '0)) ? ONE_SAT : '0;
        end else begin
          y_dir = neg ? '0 : xu;
        end
      end
      afu_pkg::KIND_SOFTSIGN: begin
        if (in_chan.func) begin
          tag_nxt.sb.op  = afu_pkg::OP_SS_DER;
          tag_nxt.sb.num = (mag64 << IP) + (d >> 1);
          tag_nxt.sb.den = DW'(d);
        end else begin
          tag_nxt.sb.op  = afu_pkg::OP_SS_VAL;
          tag_nxt.sb.num = (mag64 << (FRAC_BITS + 1)) + d;
          tag_nxt.sb.den = DW'(d << 1);
        end
      end
      afu_pkg::KIND_TANH: begin
        tag_nxt.sb.op = in_chan.func ? afu_pkg::OP_TH_DER : afu_pkg::OP_TH_VAL;
      end
      default: begin
        y_dir = xu;
      end
    endcase
    tag_nxt.sb.y_early = afu_pkg::YW_MAX'(y_dir);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vp_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
      vp_r <= exp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag0_r <= tag_nxt;
      prep_r <= prep_nxt;
    end
  end

  afu_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_tag    (tag0_r),
    .out_valid (exp_valid),
    .out_t     (exp_t),
    .out_sb    (exp_sb)
  );

  always_comb begin
    prep_nxt = exp_sb;
    if ((exp_sb.op == afu_pkg::OP_TH_VAL) || (exp_sb.op == afu_pkg::OP_TH_DER)) begin
      prep_nxt.num = ((afu_pkg::ONE_I - NW'(exp_t)) << IP)
                   + ((afu_pkg::ONE_I + NW'(exp_t)) >> 1);
      prep_nxt.den = DW'(afu_pkg::ONE_I + NW'(exp_t));
    end
  end

  afu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vp_r),
    .in_sb     (prep_r),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_sb    (div_sb)
  );

  afu_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_q      (div_q),
    .in_sb     (div_sb),
    .out_valid (out_chan.valid),
    .out_y     (out_chan.y)
  );

endmodule

@@ design/afu_exp.sv @@
module afu_exp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  afu_pkg::exp_tag_t          in_tag,
  output logic                       out_valid,
  output logic [afu_pkg::TW-1:0]     out_t,
  output afu_pkg::sb_t               out_sb
);

  localparam int NT = afu_pkg::SERIES_TERMS;
  localparam int NM = afu_pkg::MUL_STEPS;
  localparam int TW = afu_pkg::TW;
  localparam int SW = afu_pkg::SUM_W;
  localparam int FW = afu_pkg::FW;
  localparam int MW = afu_pkg::MW;

  logic [TW-1:0]     term_a [NT+1];
  logic [SW-1:0]     sum_a  [NT+1];
  afu_pkg::exp_tag_t tag_a  [NT+1];
  logic              val_a  [NT+1];

  assign term_a[0] = afu_pkg::ONE_I[TW-1:0];
  assign sum_a[0]  = afu_pkg::ONE_I[SW-1:0];
  assign tag_a[0]  = in_tag;
  assign val_a[0]  = in_valid;

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int K = i + 1;
    localparam int SHIFT = FW + $clog2(K);
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + K - 1) / K;
    localparam bit ODD = (K % 2) == 1;

    logic [2*TW-2:0]   prod1;
    logic [2*TW-2:0]   prod2;
    logic [FW-1:0]     p1_r;
    logic [2*TW-2:0]   p2_r;
    logic [SW-1:0]     s1_r;
    logic [SW-1:0]     s2_r;
    afu_pkg::exp_tag_t tag1_r;
    afu_pkg::exp_tag_t tag2_r;
    logic              v1_r;
    logic              v2_r;
    logic [TW-1:0]     term;

    assign prod1 = (2*TW-1)'(term_a[i]) * (2*TW-1)'(tag_a[i].f);
    assign prod2 = (2*TW-1)'(p1_r) * (2*TW-1)'(RECIP[TW-1:0]);
    assign term  = TW'(p2_r >> SHIFT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
      end else if (en) begin
        v1_r <= val_a[i];
        v2_r <= v1_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p1_r   <= prod1[2*FW-1:FW];
        s1_r   <= sum_a[i];
        tag1_r <= tag_a[i];
        p2_r   <= prod2;
        s2_r   <= s1_r;
        tag2_r <= tag1_r;
      end
    end

    assign term_a[i+1] = term;
    assign sum_a[i+1]  = ODD ? (s2_r - SW'(term)) : (s2_r + SW'(term));
    assign tag_a[i+1]  = tag2_r;
    assign val_a[i+1]  = v2_r;
  end

  logic [TW-1:0]     t_a   [NM+1];
  afu_pkg::exp_tag_t tagm_a [NM+1];
  logic              valm_a [NM+1];
  logic [TW-1:0]     t0_r;
  afu_pkg::exp_tag_t tag0_r;
  logic              v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= val_a[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r   <= sum_a[NT][TW-1:0];
      tag0_r <= tag_a[NT];
    end
  end

  assign t_a[0]    = t0_r;
  assign tagm_a[0] = tag0_r;
  assign valm_a[0] = v0_r;

  for (genvar j = 0; j < NM; j++) begin : g_mul
    logic [2*TW-1:0]   prod;
    logic [TW-1:0]     t_nxt;
    logic [TW-1:0]     t_r;
    afu_pkg::exp_tag_t tag_r;
    logic              v_r;

    assign prod  = (2*TW)'(t_a[j]) * (2*TW)'(afu_pkg::E_INV)
                 + (2*TW)'(afu_pkg::ONE_I >> 1);
    assign t_nxt = (MW'(j) < tagm_a[j].m) ? prod[FW+TW-1:FW] : t_a[j];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= valm_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r   <= t_nxt;
        tag_r <= tagm_a[j];
      end
    end

    assign t_a[j+1]    = t_r;
    assign tagm_a[j+1] = tag_r;
    assign valm_a[j+1] = v_r;
  end

  assign out_valid = valm_a[NM];
  assign out_t     = t_a[NM];
  assign out_sb    = tagm_a[NM].sb;

endmodule

@@ design/afu_div.sv @@
module afu_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  afu_pkg::sb_t           in_sb,
  output logic                   out_valid,
  output logic [afu_pkg::QW-1:0] out_q,
  output afu_pkg::sb_t           out_sb
);

  localparam int QW = afu_pkg::QW;
  localparam int NW = afu_pkg::NUM_W;

  afu_pkg::sb_t  sb_a [QW+1];
  logic [QW-1:0] q_a  [QW+1];
  logic          v_a  [QW+1];

  assign sb_a[0] = in_sb;
  assign q_a[0]  = '0;
  assign v_a[0]  = in_valid;

  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int BIT = QW - 1 - i;

    logic [NW-1:0] dsh;
    logic          ge;
    afu_pkg::sb_t  sb_nxt;
    logic [QW-1:0] q_nxt;
    afu_pkg::sb_t  sb_r;
    logic [QW-1:0] q_r;
    logic          v_r;

    assign dsh = NW'(sb_a[i].den) << BIT;
    assign ge  = sb_a[i].num >= dsh;

    always_comb begin
      sb_nxt = sb_a[i];
      q_nxt  = q_a[i];
      if (ge) begin
        sb_nxt.num = sb_a[i].num - dsh;
        q_nxt[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r <= sb_nxt;
        q_r  <= q_nxt;
      end
    end

    assign sb_a[i+1] = sb_r;
    assign q_a[i+1]  = q_r;
    assign v_a[i+1]  = v_r;
  end

  assign out_valid = v_a[QW];
  assign out_q     = q_a[QW];
  assign out_sb    = sb_a[QW];

endmodule

@@ design/afu_post.sv @@
module afu_post #(
  parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [afu_pkg::QW-1:0] in_q,
  input  afu_pkg::sb_t           in_sb,
  output logic                   out_valid,
  output logic [DATA_WIDTH-1:0]  out_y
);

  localparam int TW = afu_pkg::TW;
  localparam int PW = 2 * TW;
  localparam int SH_LO = afu_pkg::IP - FRAC_BITS;
  localparam int SH_HI = 2 * afu_pkg::IP - FRAC_BITS;
  localparam logic [63:0] MAX_POS = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] MAX_NEG = 64'd1 << (DATA_WIDTH - 1);
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * afu_pkg::IP);

  logic [TW-1:0]             th;
  logic [TW:0]               om;
  logic [TW:0]               mul_b;
  logic [PW-1:0]             prod;
  logic                      is_ss;

  afu_pkg::op_t              op1_r;
  logic                      neg1_r;
  logic [afu_pkg::YW_MAX-1:0] y1_r;
  logic [TW-1:0]             th1_r;
  logic [PW-1:0]             p1_r;
  logic                      v1_r;

  logic [63:0]               mag;
  logic [63:0]               clip;
  logic                      ng;
  logic [DATA_WIDTH-1:0]     y_nxt;
  logic [DATA_WIDTH-1:0]     y2_r;
  logic                      v2_r;

  assign is_ss = (in_sb.op == afu_pkg::OP_SS_VAL) || (in_sb.op == afu_pkg::OP_SS_DER);
  assign th    = (!is_ss && in_sb.big) ? afu_pkg::ONE_I[TW-1:0] : in_q;
  assign om    = in_sb.neg ? ((TW+1)'(afu_pkg::ONE_I) + (TW+1)'(in_q))
                           : ((TW+1)'(afu_pkg::ONE_I) - (TW+1)'(in_q));
  assign mul_b = is_ss ? om : (TW+1)'(th);
  assign prod  = PW'((2*TW+1)'(th) * (2*TW+1)'(mul_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_sb.op;
      neg1_r <= in_sb.neg;
      y1_r   <= in_sb.y_early;
      th1_r  <= th;
      p1_r   <= prod;
      y2_r   <= y_nxt;
    end
  end

  always_comb begin
    mag = '0;
    ng  = 1'b0;
    case (op1_r)
      afu_pkg::OP_SS_VAL: begin
        mag = 64'(th1_r);
        ng  = neg1_r;
      end
      afu_pkg::OP_SS_DER: begin
        mag = (64'(p1_r) + (64'd1 << (SH_HI - 1))) >> SH_HI;
        ng  = neg1_r && (p1_r != '0);
      end
      afu_pkg::OP_TH_VAL: begin
        mag = (64'(th1_r) + (64'd1 << (SH_LO - 1))) >> SH_LO;
        ng  = neg1_r;
      end
      afu_pkg::OP_TH_DER: begin
        mag = ((ONE_SQ - 64'(p1_r)) + (64'd1 << (SH_HI - 1))) >> SH_HI;
        ng  = 1'b0;
      end
      default: begin
        mag = '0;
        ng  = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ng) begin
      clip  = (mag > MAX_NEG) ? MAX_NEG : mag;
      y_nxt = DATA_WIDTH'(64'd0 - clip);
    end else begin
      clip  = (mag > MAX_POS) ? MAX_POS : mag;
      y_nxt = DATA_WIDTH'(clip);
    end
    if (op1_r == afu_pkg::OP_DIRECT) begin
      y_nxt = y1_r[DATA_WIDTH-1:0];
    end
  end

  assign out_valid = v2_r;
  assign out_y     = y2_r;

endmodule

@@ design/afu_chk.sv @@
module afu_chk #(
  parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_y
);

  // A waiting result request stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_y))
    else $error("result changed while stalled");

  // The input side is open whenever the output side can move.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although output is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request right after reset");

endmodule

bind activation_function_unit afu_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_afu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_y     (out_chan.y)
);

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int FB = 11;
  localparam longint unsigned QONE = 64'd1 << 30;
  localparam int WATCH_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic          func;
    logic [DW-1:0] x;
  } sample_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  afu_in_if #(.DATA_WIDTH(DW)) in_if ();
  afu_out_if #(.DATA_WIDTH(DW)) out_if ();

  activation_function_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  sample_t pending_q[$];
  logic [DW-1:0] expected_y_q[$];
  afu_pkg::kind_t active_kind;
  int errors;
  int in_gap;
  int hold_cnt;
  bit long_hold_req;
  bit in_taken;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned clamp_pack(bit neg, longint unsigned mag);
    if (!neg) begin
      if (mag > 64'd32767) mag = 64'd32767;
      return mag & 64'hFFFF;
    end
    if (mag > 64'd32768) mag = 64'd32768;
    return (64'd0 - mag) & 64'hFFFF;
  endfunction

  function automatic longint unsigned round_shift(longint unsigned v, int sh);
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint unsigned exp_series(longint unsigned f);
    longint unsigned sum;
    longint unsigned term;
    sum = QONE;
    term = QONE;
    for (int k = 1; k <= 20; k++) begin
      term = (term * f) >> 30;
      term = term / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned tanh_q30(longint unsigned mag);
    longint unsigned a;
    longint unsigned t;
    longint unsigned e1;
    longint unsigned m;
    if (mag >= (64'd16 << FB)) return QONE;
    a = (mag << (30 - FB)) << 1;
    m = a >> 30;
    t = exp_series(a & (QONE - 1));
    e1 = exp_series(QONE);
    for (longint unsigned i = 0; i < m; i++) t = (t * e1 + (QONE >> 1)) >> 30;
    return (((QONE - t) << 30) + ((QONE + t) >> 1)) / (QONE + t);
  endfunction

  function automatic logic [DW-1:0] activation_of(afu_pkg::kind_t k, logic func,
                                                  logic [DW-1:0] x);
    longint unsigned raw;
    longint unsigned mag;
    longint unsigned d;
    longint unsigned s30;
    longint unsigned om;
    longint unsigned p;
    longint unsigned th;
    longint unsigned one_out;
    bit neg;
    raw = 64'(x);
    neg = x[DW-1];
    mag = neg ? ((64'd0 - raw) & 64'hFFFF) : raw;
    if (neg && mag == 0) mag = 64'd32768;
    one_out = 64'd1 << FB;
    case (k)
      afu_pkg::KIND_IDENT: begin
        return DW'(func ? clamp_pack(1'b0, one_out) : raw);
      end
      afu_pkg::KIND_RELU: begin
        if (func) return DW'((!neg && mag != 0) ? clamp_pack(1'b0, one_out) : 64'd0);
        return DW'(neg ? 64'd0 : raw);
      end
      afu_pkg::KIND_SOFTSIGN: begin
        d = one_out + mag;
        if (!func) return DW'(clamp_pack(neg, (2 * mag * one_out + d) / (2 * d)));
        s30 = ((mag << 30) + (d >> 1)) / d;
        om = neg ? QONE + s30 : QONE - s30;
        p = s30 * om;
        return DW'(clamp_pack(neg && p != 0, round_shift(p, 60 - FB)));
      end
      default: begin
        th = tanh_q30(mag);
        if (!func) return DW'(clamp_pack(neg, round_shift(th, 30 - FB)));
        return DW'(clamp_pack(1'b0, round_shift(QONE * QONE - th * th, 60 - FB)));
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  always @(posedge clk) begin
    in_taken = rst_n && in_if.valid && in_if.ready;
    if (in_taken) expected_y_q.push_back(activation_of(active_kind, in_if.func, in_if.x));
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_y_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.y, '0);
      end else begin
        if (out_if.y !== expected_y_q[0]) report_mismatch("y", out_if.y, expected_y_q[0]);
        void'(expected_y_q.pop_front());
      end
    end
    if (in_taken || (out_if.valid && out_if.ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!in_if.valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.func <= pending_q[0].func;
        in_if.x <= pending_q[0].x;
        void'(pending_q.pop_front());
        if ($urandom_range(0, 99) < 25) begin
          in_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_cnt <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      hold_cnt <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                               : $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic write_kind(afu_pkg::kind_t k);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_kind = k;
  endtask

  task automatic queue_sample(logic func, logic [DW-1:0] x);
    sample_t s;
    s.func = func;
    s.x = x;
    pending_q.push_back(s);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_if.valid || expected_y_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    logic [DW-1:0] x;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: x = DW'($urandom());
        1: x = DW'($urandom_range(0, 8191) - 4096);
        2: x = DW'($urandom_range(0, 255) - 128);
        default: x = ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF) ^ DW'($urandom_range(0, 15));
      endcase
      queue_sample(1'($urandom_range(0, 1)), x);
    end
  endtask

  initial begin
    afu_pkg::kind_t plan[8];
    logic [DW-1:0] corners[12];
    plan = '{afu_pkg::KIND_IDENT, afu_pkg::KIND_RELU, afu_pkg::KIND_SOFTSIGN,
             afu_pkg::KIND_TANH, afu_pkg::KIND_TANH, afu_pkg::KIND_SOFTSIGN,
             afu_pkg::KIND_RELU, afu_pkg::KIND_IDENT};
    corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
                16'h0800, 16'hF800, 16'h07FF, 16'h4000, 16'hC000, 16'h0400};
    errors = 0;
    in_gap = 0;
    hold_cnt = 0;
    long_hold_req = 0;
    in_taken = 0;
    idle_cycles = 0;
    active_kind = afu_pkg::KIND_IDENT;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = 1'b0;
    in_if.x = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      write_kind(plan[ph]);
      if (ph < 4) begin
        foreach (corners[i]) begin
          queue_sample(1'b0, corners[i]);
          queue_sample(1'b1, corners[i]);
        end
      end
      if (ph == 3) long_hold_req = 1'b1;
      queue_random(ph < 4 ? 60 : 90);
      drain();
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
